[rtl/summary_histogram_accumulator_defines.svh]
// Assertion macros for the summary histogram accumulator.
`ifndef SUMMARY_HISTOGRAM_ACCUMULATOR_DEFINES_SVH
`define SUMMARY_HISTOGRAM_ACCUMULATOR_DEFINES_SVH

// Checked while out of reset.
`define SHACC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define SHACC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/shacc_pkg.sv]
// Shared types, constants and functions of the summary histogram accumulator.
`default_nettype none

package shacc_pkg;

   localparam int COLUMN_W    = 4;
   localparam int ROW_W       = 10;
   localparam int SAMPLE_W    = 32;
   localparam int COUNT_W     = 16;
   localparam int SHIFT_W     = 6;
   localparam int YSB_W       = 4;
   localparam int XCH_W       = 5;
   localparam int NUM_SHIFTS  = 16;
   localparam int FUNC_W      = 2;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   localparam logic [YSB_W-1:0] YSB_RESET = 4'd10;
   localparam logic [XCH_W-1:0] XCH_RESET = 5'd16;

   localparam logic [CSR_INDEX_W-1:0] CSR_Y_SCALE    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_CHANNELS = 1'b1;

   typedef enum logic [1:0] {
      FUNC_INC   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_SHIFT = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_SKIPPED = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_INC   = 2'd3
   } op_kind_type;

   typedef struct packed {
      logic [YSB_W-1:0] y_scale_bits;
      logic [XCH_W-1:0] x_channels_in_use;
   } cfg_type;

   typedef struct packed {
      op_kind_type        kind;
      status_type         status;
      logic [COUNT_W-1:0] wr_count;
   } cmd_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] read_count;
   } rsp_type;

   // Positive code shifts right, negative shifts left; a left shift of 32 gives zero.
   function automatic logic [SAMPLE_W-1:0] scale_value(input logic [SAMPLE_W-1:0] v,
                                                       input logic [SHIFT_W-1:0] code);
      logic [SHIFT_W-1:0]  mag;
      logic [SAMPLE_W-1:0] res;
      mag = 6'd0 - code;
      if (!code[SHIFT_W-1]) begin
         res = v >> code;
      end else if (mag[SHIFT_W-1]) begin
         res = '0;
      end else begin
         res = v << mag[SHIFT_W-2:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/shacc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module shacc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/shacc_queue.sv]
// Short command queue between the classifying front and the bin update back.
`default_nettype none

module shacc_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [WIDTH-1:0] entry_in [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/shacc_front.sv]
// Front part: accepts items, scales samples, range-checks and forms bin commands.
`default_nettype none

module shacc_front import shacc_pkg::*; #(
   parameter int MAX_COLUMNS  = 16,
   parameter int MAX_ROW_BITS = 10,
   localparam int ADDR_W = $clog2(MAX_COLUMNS << MAX_ROW_BITS)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                hold,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire func_type            req_func,
   input  wire logic [COLUMN_W-1:0] req_column,
   input  wire logic [ROW_W-1:0]    req_row,
   input  wire logic [SAMPLE_W-1:0] req_sample_value,
   input  wire logic                req_sample_valid,
   input  wire logic [COUNT_W-1:0]  req_write_count,
   input  wire logic [SHIFT_W-1:0]  req_shift_amount,
   output logic                     cmd_valid,
   input  wire logic                cmd_ready,
   output cmd_type                  cmd,
   output logic      [ADDR_W-1:0]   cmd_addr
);

   typedef struct packed {
      func_type            func;
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic [SAMPLE_W-1:0] scaled;
      logic                sample_valid;
      logic [COUNT_W-1:0]  wr_count;
      logic                col_ok;
   } f1_type;

   logic [SHIFT_W-1:0]      shift_ff [NUM_SHIFTS];
   logic [SHIFT_W-1:0]      shift_in [NUM_SHIFTS];
   logic                    f1_valid_ff, f1_valid_in;
   f1_type                  f1_ff, f1_in;
   logic                    accept;
   logic                    col_ok;
   logic [4:0]              ebits;
   logic [SAMPLE_W-1:0]     hi_mask;
   logic                    y_fits;
   logic                    row_fits;
   logic [MAX_ROW_BITS-1:0] row_sel;

   assign req_tready = !hold && (!f1_valid_ff || cmd_ready);
   assign accept     = req_tvalid && req_tready;
   assign col_ok     = ({1'b0, req_column} < cfg.x_channels_in_use) &&
                       (int'(req_column) < MAX_COLUMNS);

   always_comb begin
      shift_in = shift_ff;
      if (accept && req_func == FUNC_SHIFT && col_ok) begin
         shift_in[req_column] = req_shift_amount;
      end
   end

   always_comb begin
      f1_in = f1_ff;
      if (accept) begin
         f1_in.func         = req_func;
         f1_in.column       = req_column;
         f1_in.row          = req_row;
         f1_in.scaled       = scale_value(req_sample_value, shift_ff[req_column]);
         f1_in.sample_valid = req_sample_valid;
         f1_in.wr_count     = req_write_count;
         f1_in.col_ok       = col_ok;
      end
      if (accept) begin
         f1_valid_in = 1'b1;
      end else if (cmd_ready) begin
         f1_valid_in = 1'b0;
      end else begin
         f1_valid_in = f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_ff <= f1_in;
      if (reset) begin
         f1_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SHIFTS; i++) begin
            shift_ff[i] <= '0;
         end
      end else begin
         f1_valid_ff <= f1_valid_in;
         shift_ff    <= shift_in;
      end
   end

   assign ebits    = (5'(cfg.y_scale_bits) > 5'(MAX_ROW_BITS)) ? 5'(MAX_ROW_BITS)
                                                               : 5'(cfg.y_scale_bits);
   assign hi_mask  = ~32'd0 << ebits;
   assign y_fits   = (f1_ff.scaled & hi_mask) == '0;
   assign row_fits = (32'(f1_ff.row) & hi_mask) == '0;
   assign row_sel  = (f1_ff.func == FUNC_INC) ? f1_ff.scaled[MAX_ROW_BITS-1:0]
                                              : MAX_ROW_BITS'(f1_ff.row);
   assign cmd_addr = ADDR_W'(row_sel) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(f1_ff.column);
   assign cmd_valid = f1_valid_ff;

   always_comb begin
      cmd.kind     = OP_NONE;
      cmd.status   = ST_DONE;
      cmd.wr_count = f1_ff.wr_count;
      if (!f1_ff.col_ok) begin
         cmd.status = ST_RANGE;
      end else begin
         case (f1_ff.func)
            FUNC_INC: begin
               if (!f1_ff.sample_valid) begin
                  cmd.status = ST_SKIPPED;
               end else if (!y_fits) begin
                  cmd.status = ST_RANGE;
               end else begin
                  cmd.kind = OP_INC;
               end
            end
            FUNC_READ, FUNC_WRITE: begin
               if (!row_fits) begin
                  cmd.status = ST_RANGE;
               end else begin
                  cmd.kind = (f1_ff.func == FUNC_READ) ? OP_READ : OP_WRITE;
               end
            end
            default: begin
               cmd.kind = OP_NONE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/shacc_back.sv]
// Back part: clears the bin store, then reads, writes and increments bins with forwarding.
`default_nettype none

module shacc_back import shacc_pkg::*; #(
   parameter int MAX_COLUMNS  = 16,
   parameter int MAX_ROW_BITS = 10,
   localparam int DEPTH  = MAX_COLUMNS << MAX_ROW_BITS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   output logic                   clear_busy,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire cmd_type           cmd,
   input  wire logic [ADDR_W-1:0] cmd_addr,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp
);

   logic               clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               b_valid_ff, b_valid_in;
   cmd_type            b_cmd_ff, b_cmd_in;
   logic [ADDR_W-1:0]  b_addr_ff, b_addr_in;
   logic               lw_valid_ff, lw_valid_in;
   logic [ADDR_W-1:0]  lw_addr_ff, lw_addr_in;
   logic [COUNT_W-1:0] lw_data_ff, lw_data_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               b_fire;
   logic               issue;
   logic               b_write;
   logic [COUNT_W-1:0] rd_data;
   logic [COUNT_W-1:0] old_count;
   logic [COUNT_W-1:0] new_count;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [COUNT_W-1:0] ram_wdata;

   assign clear_busy = clr_active_ff;
   assign b_fire     = b_valid_ff && (!out_valid_ff || rsp_ready);
   assign cmd_ready  = !clr_active_ff && (!b_valid_ff || b_fire);
   assign issue      = cmd_valid && cmd_ready;
   assign old_count  = (lw_valid_ff && lw_addr_ff == b_addr_ff) ? lw_data_ff : rd_data;
   assign new_count  = (b_cmd_ff.kind == OP_INC) ? old_count + 1'b1 : b_cmd_ff.wr_count;
   assign b_write    = b_fire && (b_cmd_ff.kind == OP_WRITE || b_cmd_ff.kind == OP_INC);
   assign ram_we     = clr_active_ff || b_write;
   assign ram_waddr  = clr_active_ff ? clr_addr_ff : b_addr_ff;
   assign ram_wdata  = clr_active_ff ? '0 : new_count;

   shacc_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (cmd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end

      b_cmd_in  = b_cmd_ff;
      b_addr_in = b_addr_ff;
      if (issue) begin
         b_cmd_in   = cmd;
         b_addr_in  = cmd_addr;
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end

      lw_valid_in = lw_valid_ff;
      lw_addr_in  = lw_addr_ff;
      lw_data_in  = lw_data_ff;
      if (clr_active_ff) begin
         lw_valid_in = 1'b0;
      end else if (b_write) begin
         lw_valid_in = 1'b1;
         lw_addr_in  = b_addr_ff;
         lw_data_in  = new_count;
      end

      out_in = out_ff;
      if (b_fire) begin
         out_in.status     = b_cmd_ff.status;
         out_in.read_count = (b_cmd_ff.kind == OP_READ) ? old_count : '0;
         out_valid_in      = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_cmd_ff   <= b_cmd_in;
      b_addr_ff  <= b_addr_in;
      lw_addr_ff <= lw_addr_in;
      lw_data_ff <= lw_data_in;
      out_ff     <= out_in;
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         b_valid_ff    <= 1'b0;
         lw_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         b_valid_ff    <= b_valid_in;
         lw_valid_ff   <= lw_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

`default_nettype wire

[rtl/summary_histogram_accumulator.sv]
// Top level of the summary histogram accumulator: configuration registers, front, queue, back.
// Path: an item passes the front register, the command queue and the back stage, which reads
// its bin on entry and writes it on leaving, then the result register; a stall holds it.
// Throughput: one item per cycle while results are taken and the store is not being cleared,
// set by the single read and single write port of the bin store, with write forwarding.
// Reset: synchronous; afterwards the store is swept to zero, all MAX_COLUMNS << MAX_ROW_BITS
// bins (16384 by default), with req_tready low; configuration writes are taken throughout.
`default_nettype none

module summary_histogram_accumulator import shacc_pkg::*; #(
   parameter int MAX_COLUMNS  = 16,
   parameter int MAX_ROW_BITS = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // column[3:0], row[13:4], sample_value[45:14], sample_valid[46],
   // write_count[62:47], shift_amount[68:63], zero fill[71:69]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // func[1:0]
   input  wire logic [FUNC_W-1:0]      req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // read_count[15:0], status[17:16], zero fill[23:18]
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W      = $clog2(MAX_COLUMNS << MAX_ROW_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_W     = ADDR_W + $bits(cmd_type);

   cfg_type              cfg_ff, cfg_in;
   logic                 clear_busy;
   logic                 f_valid;
   logic                 f_ready;
   cmd_type              f_cmd;
   logic [ADDR_W-1:0]    f_addr;
   logic                 b_valid;
   logic                 b_ready;
   logic [QUEUE_W-1:0]   b_data;
   rsp_type              rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_Y_SCALE:    cfg_in.y_scale_bits      = csr_wdata[YSB_W-1:0];
            CSR_X_CHANNELS: cfg_in.x_channels_in_use = csr_wdata[XCH_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.y_scale_bits      <= YSB_RESET;
         cfg_ff.x_channels_in_use <= XCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   shacc_front #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .MAX_ROW_BITS (MAX_ROW_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .hold             (clear_busy),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_func         (func_type'(req_tuser)),
      .req_column       (req_tdata[3:0]),
      .req_row          (req_tdata[13:4]),
      .req_sample_value (req_tdata[45:14]),
      .req_sample_valid (req_tdata[46]),
      .req_write_count  (req_tdata[62:47]),
      .req_shift_amount (req_tdata[68:63]),
      .cmd_valid        (f_valid),
      .cmd_ready        (f_ready),
      .cmd              (f_cmd),
      .cmd_addr         (f_addr)
   );

   shacc_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_addr, f_cmd}),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   shacc_back #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .MAX_ROW_BITS (MAX_ROW_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .cmd_valid  (b_valid),
      .cmd_ready  (b_ready),
      .cmd        (cmd_type'(b_data[$bits(cmd_type)-1:0])),
      .cmd_addr   (b_data[QUEUE_W-1:$bits(cmd_type)]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp);

endmodule

`default_nettype wire

[rtl/shacc_checker.sv]
// Port-level assertions for the summary histogram accumulator and their bind.
`default_nettype none

`include "summary_histogram_accumulator_defines.svh"

module shacc_checker import shacc_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [1:0]         rsp_status;
   logic [COUNT_W-1:0] rsp_count;

   assign rsp_status = rsp_tdata[COUNT_W +: 2];
   assign rsp_count  = rsp_tdata[COUNT_W-1:0];

   `SHACC_ASSERT_RST(a_reset_quiet, reset |=> !req_tready && !rsp_tvalid, "ports not quiet after reset")
   `SHACC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `SHACC_ASSERT(a_status_code, rsp_tvalid |-> rsp_status == ST_DONE || rsp_status == ST_SKIPPED || rsp_status == ST_RANGE, "undefined status")
   `SHACC_ASSERT(a_fail_no_count, rsp_tvalid && rsp_status != ST_DONE |-> rsp_count == '0, "count on failed transfer")

endmodule

bind summary_histogram_accumulator shacc_checker u_chk (.*);

`default_nettype wire

[bench/summary_histogram_accumulator_tb.sv]
// Self-checking testbench for the summary histogram accumulator: directed table, then random phases.
`default_nettype none

module summary_histogram_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import shacc_pkg::*;

   localparam int BIN_COLUMNS   = 16;
   localparam int ROW_BITS_MAX  = 10;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int PHASE_ITEMS   = 120;
   localparam int NUM_PHASES    = 6;
   localparam int HOLDOFF_CYCLES = 300;

   typedef struct {
      func_type              func;
      logic [COLUMN_W-1:0]   column;
      logic [ROW_W-1:0]      row;
      logic [SAMPLE_W-1:0]   sample;
      logic                  valid;
      logic [COUNT_W-1:0]    wcount;
      logic [SHIFT_W-1:0]    shamt;
   } hist_req_type;

   typedef struct {
      logic [COUNT_W-1:0] count;
      status_type         status;
   } hist_rsp_type;

   typedef struct {
      bit                    is_setting;
      logic [CSR_DATA_W-1:0] ysb_data;
      logic [CSR_DATA_W-1:0] xch_data;
      hist_req_type          req;
      bit                    typed;
      hist_rsp_type          rsp;
   } step_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   summary_histogram_accumulator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   logic [COUNT_W-1:0]    bin_model [BIN_COLUMNS << ROW_BITS_MAX];
   logic [SHIFT_W-1:0]    shift_model [NUM_SHIFTS];
   logic [YSB_W-1:0]      ysb_cfg = YSB_RESET;
   logic [XCH_W-1:0]      xch_cfg = XCH_RESET;
   hist_rsp_type          owed_results [$];
   hist_rsp_type          owed_head;
   int                    mismatch_count = 0;
   int                    send_idle_pct  = 0;
   int                    rsp_stall_pct  = 0;
   int                    rsp_hold_left  = 0;
   int                    timeout_cycles;
   logic [CSR_DATA_W-1:0] phase_ysb [NUM_PHASES] = '{5'd26, 5'd1, 5'd4, 5'd15, 5'd6, 5'd2};
   logic [CSR_DATA_W-1:0] phase_xch [NUM_PHASES] = '{5'd16, 5'd1, 5'd9, 5'd31, 5'd16, 5'd3};

   function automatic int unsigned rows_now();
      return 1 << ((ysb_cfg > ROW_BITS_MAX) ? ROW_BITS_MAX : ysb_cfg);
   endfunction

   function automatic int unsigned cols_now();
      return (xch_cfg > BIN_COLUMNS) ? BIN_COLUMNS : xch_cfg;
   endfunction

   // Apply one transfer to the bin and shift copies and return the result it owes.
   function automatic hist_rsp_type histogram_outcome(input hist_req_type q);
      hist_rsp_type        r;
      logic [SHIFT_W-1:0]  code;
      logic [SHIFT_W-1:0]  mag;
      logic [SAMPLE_W-1:0] scaled;
      int unsigned         slot;
      r.count  = '0;
      r.status = ST_DONE;
      if (q.column >= cols_now()) begin
         r.status = ST_RANGE;
      end else begin
         case (q.func)
            FUNC_INC: begin
               if (!q.valid) begin
                  r.status = ST_SKIPPED;
               end else begin
                  code = shift_model[q.column];
                  mag  = ~code + 1'b1;
                  if (!code[SHIFT_W-1]) begin
                     scaled = q.sample >> code;
                  end else if (mag >= 6'd32) begin
                     scaled = '0;
                  end else begin
                     scaled = q.sample << mag;
                  end
                  if (scaled < rows_now()) begin
                     slot = scaled * BIN_COLUMNS + q.column;
                     bin_model[slot] = bin_model[slot] + 1'b1;
                  end else begin
                     r.status = ST_RANGE;
                  end
               end
            end
            FUNC_READ, FUNC_WRITE: begin
               if (q.row >= rows_now()) begin
                  r.status = ST_RANGE;
               end else begin
                  slot = q.row * BIN_COLUMNS + q.column;
                  if (q.func == FUNC_READ) begin
                     r.count = bin_model[slot];
                  end else begin
                     bin_model[slot] = q.wcount;
                  end
               end
            end
            default: begin
               shift_model[q.column] = q.shamt;
            end
         endcase
      end
      return r;
   endfunction

   function automatic step_type mk_op(input func_type f, input logic [COLUMN_W-1:0] col,
                                      input logic [ROW_W-1:0] row,
                                      input logic [SAMPLE_W-1:0] smp,
                                      input logic vld, input logic [COUNT_W-1:0] wc,
                                      input logic [SHIFT_W-1:0] sh, input bit typed,
                                      input logic [COUNT_W-1:0] cnt, input status_type stat);
      step_type s;
      s.is_setting = 1'b0;
      s.req.func   = f;
      s.req.column = col;
      s.req.row    = row;
      s.req.sample = smp;
      s.req.valid  = vld;
      s.req.wcount = wc;
      s.req.shamt  = sh;
      s.typed      = typed;
      s.rsp.count  = cnt;
      s.rsp.status = stat;
      return s;
   endfunction

   function automatic step_type mk_setting(input logic [CSR_DATA_W-1:0] ysb,
                                           input logic [CSR_DATA_W-1:0] xch);
      step_type s;
      s.is_setting = 1'b1;
      s.ysb_data   = ysb;
      s.xch_data   = xch;
      s.typed      = 1'b0;
      return s;
   endfunction

   // Random transfers; increments are mostly well-aimed: pick a row, then build a sample that scales onto it.
   function automatic hist_req_type random_req();
      hist_req_type        q;
      int unsigned         n_rows;
      int unsigned         n_cols;
      int unsigned         pick;
      int unsigned         hot;
      logic [SHIFT_W-1:0]  code;
      logic [SHIFT_W-1:0]  mag;
      logic [SAMPLE_W-1:0] target;
      n_rows = rows_now();
      n_cols = cols_now();
      pick   = $urandom_range(0, 99);
      q.func = (pick < 50) ? FUNC_INC : (pick < 70) ? FUNC_READ :
               (pick < 85) ? FUNC_WRITE : FUNC_SHIFT;
      q.column = (n_cols != 0 && $urandom_range(0, 99) < 85) ?
                 COLUMN_W'($urandom_range(0, n_cols - 1)) : COLUMN_W'($urandom);
      hot = (n_rows < 4) ? n_rows : 4;
      if ($urandom_range(0, 99) < 50) begin
         q.row = ROW_W'($urandom_range(0, hot - 1));
      end else if ($urandom_range(0, 99) < 80) begin
         q.row = ROW_W'($urandom_range(0, n_rows - 1));
      end else begin
         q.row = ROW_W'($urandom);
      end
      q.valid  = ($urandom_range(0, 99) < 90);
      q.wcount = COUNT_W'($urandom);
      q.shamt  = SHIFT_W'($urandom);
      q.sample = $urandom;
      if (q.func == FUNC_INC && $urandom_range(0, 99) < 75) begin
         target = SAMPLE_W'(q.row);
         code   = shift_model[q.column];
         mag    = ~code + 1'b1;
         if (!code[SHIFT_W-1]) begin
            q.sample = (target << code) | (q.sample & ((32'd1 << code) - 1));
         end else if (mag < 6'd32) begin
            q.sample = (q.sample << (6'd32 - mag)) | (target >> mag);
         end
      end
      return q;
   endfunction

   task automatic offer(input hist_req_type q);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= q.func;
      req_tdata  <= {3'b000, q.shamt, q.wcount, q.valid, q.sample, q.row, q.column};
      do @(posedge clock); while (!req_tready);
      owed_results = {owed_results, histogram_outcome(q)};
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] ysb,
                                input logic [CSR_DATA_W-1:0] xch);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_Y_SCALE;
      csr_wdata <= ysb;
      ysb_cfg    = ysb[YSB_W-1:0];
      @(negedge clock);
      csr_index <= CSR_X_CHANNELS;
      csr_wdata <= xch;
      xch_cfg    = xch;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with none owed, read_count %h status %0d",
                     $time, rsp_tdata[15:0], rsp_tdata[17:16]);
         end else begin
            owed_head = owed_results.pop_front();
            if (rsp_tdata[15:0] !== owed_head.count) begin
               mismatch_count++;
               $display("%0t: read_count expected %h actual %h",
                        $time, owed_head.count, rsp_tdata[15:0]);
            end
            if (rsp_tdata[17:16] !== owed_head.status) begin
               mismatch_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, owed_head.status, rsp_tdata[17:16]);
            end
         end
      end
   end

   initial begin
      for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++) begin
         @(posedge clock);
      end
      $display("[summary_histogram_accumulator] ERROR");
      $finish;
   end

   initial begin
      step_type plan [$];
      foreach (bin_model[i]) bin_model[i] = '0;
      foreach (shift_model[i]) shift_model[i] = '0;

      plan = {plan, mk_op(FUNC_READ,  0,    0, 0,            0, 0,        0,     1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_READ,  15, 1023, 0,           0, 0,        0,     1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_INC,   0,    0, 5,            0, 0,        0,     1, 0,
                          ST_SKIPPED)};
      plan = {plan, mk_op(FUNC_INC,   0,    0, 5,            1, 0,        0,     1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_READ,  0,    5, 0,            0, 0,        0,     0, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_INC,   3,    0, 1024,         1, 0,        0,     1, 0, ST_RANGE)};
      plan = {plan, mk_op(FUNC_INC,   3,    0, 32'hFFFF_FFFF, 1, 0,       0,     1, 0, ST_RANGE)};
      plan = {plan, mk_op(FUNC_WRITE, 15, 1023, 0,           0, 16'hFFFF, 0,     1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_INC,   15,   0, 1023,         1, 0,        0,     0, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_READ,  15, 1023, 0,           0, 0,        0,     0, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_SHIFT, 1,    0, 0,            0, 0,        6'h20, 1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_INC,   1,    0, 32'hFFFF_FFFF, 1, 0,       0,     0, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_READ,  1,    0, 0,            0, 0,        0,     0, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_SHIFT, 2,    0, 0,            0, 0,        6'h1F, 1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_INC,   2,    0, 32'hFFFF_FFFF, 1, 0,       0,     0, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_SHIFT, 4,    0, 0,            0, 0,        6'h21, 1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_INC,   4,    0, 1,            1, 0,        0,     1, 0, ST_RANGE)};
      plan = {plan, mk_op(FUNC_SHIFT, 5,    0, 0,            0, 0,        6'h3F, 1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_INC,   5,    0, 511,          1, 0,        0,     0, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_READ,  5, 1022, 0,            0, 0,        0,     0, 0, ST_DONE)};
      plan = {plan, mk_setting(5'd3, 5'd4)};
      plan = {plan, mk_op(FUNC_READ,  2,    8, 0,            0, 0,        0,     1, 0, ST_RANGE)};
      plan = {plan, mk_op(FUNC_WRITE, 3,    7, 0,            0, 16'hA5C3, 0,     1, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_SHIFT, 4,    0, 0,            0, 0,        6'h05, 1, 0, ST_RANGE)};
      plan = {plan, mk_op(FUNC_READ,  3,    7, 0,            0, 0,        0,     0, 0, ST_DONE)};
      plan = {plan, mk_setting(5'd0, 5'd0)};
      plan = {plan, mk_op(FUNC_READ,  0,    0, 0,            0, 0,        0,     1, 0, ST_RANGE)};
      plan = {plan, mk_setting(5'd0, 5'd31)};
      plan = {plan, mk_op(FUNC_INC,   15,   0, 1,            1, 0,        0,     0, 0, ST_DONE)};
      plan = {plan, mk_op(FUNC_INC,   15,   0, 0,            1, 0,        0,     0, 0, ST_DONE)};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_setting) begin
            apply_setting(plan[i].ysb_data, plan[i].xch_data);
         end else begin
            offer(plan[i].req);
            if (plan[i].typed) owed_results[owed_results.size() - 1] = plan[i].rsp;
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_setting(phase_ysb[p], phase_xch[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         // hold the result side off so the block backs up into its input
         if (p == 4) rsp_hold_left = HOLDOFF_CYCLES;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == PHASE_ITEMS / 2) drain();
            offer(random_req());
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("[summary_histogram_accumulator] OK");
      end else begin
         $display("[summary_histogram_accumulator] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

[summary_histogram_accumulator.f]
+incdir+rtl
rtl/shacc_pkg.sv
rtl/shacc_ram.sv
rtl/shacc_queue.sv
rtl/shacc_front.sv
rtl/shacc_back.sv
rtl/summary_histogram_accumulator.sv
rtl/shacc_checker.sv
bench/summary_histogram_accumulator_tb.sv
